@@ src/dsl_pkg.sv @@
package dsl_pkg;

    // Lexer modes
    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_NUMBER  = 4'd1,
        M_IDENT   = 4'd2,
        M_CODE    = 4'd3,
        M_WAIT    = 4'd4,
        M_DOLLAR  = 4'd5,
        M_COND    = 4'd6,
        M_STRING  = 4'd7,
        M_COMMENT = 4'd8
    } lex_mode_t;

    // Token kinds
    typedef enum logic [3:0] {
        K_END    = 4'd0,
        K_ASSIGN = 4'd1,
        K_COLON  = 4'd2,
        K_CODE   = 4'd3,
        K_GOTO   = 4'd4,
        K_IDENT  = 4'd5,
        K_NUMBER = 4'd6,
        K_COND   = 4'd7,
        K_STRING = 4'd8,
        K_DOLLAR = 4'd9,
        K_WAIT   = 4'd10
    } tok_kind_t;

    localparam int TOK_OFF_W = 16;
    localparam int MAX_TOK   = 3;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam logic [3:0] KW_LEN = 4'd9;

    // Byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_USCORE = 8'h5F;

    typedef struct packed {
        tok_kind_t              kind;
        logic [TOK_OFF_W-1:0]   start;
        logic [TOK_OFF_W-1:0]   stop;
    } tok_t;

    // Tokens caused by one input item, slot 0 first
    typedef struct packed {
        logic [1:0]             cnt;
        tok_t [MAX_TOK-1:0]     toks;
    } bundle_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } q_stat_t;

    // Keyword text "waitwhile"
    function automatic logic [7:0] kw_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0, 4'd4: c = 8'h77;  // w
            4'd1:       c = 8'h61;  // a
            4'd2, 4'd6: c = 8'h69;  // i
            4'd3:       c = 8'h74;  // t
            4'd5:       c = 8'h68;  // h
            4'd7:       c = 8'h6C;  // l
            4'd8:       c = 8'h65;  // e
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        logic [7:0] l;
        l = b | 8'h20;
        return (l >= 8'h61) && (l <= 8'h7A);
    endfunction

endpackage

@@ src/dialog_script_lexer.sv @@
// Streaming lexer for dialog script text. One byte enters per s_ item
// (s_tdata), s_tlast marks end of stream, and tokens leave on m_ with the
// kind in m_tuser, start/stop offsets in m_tdata, and m_tlast on the last
// token an input item caused. The front lexer takes one byte every cycle
// while the queue has room; an item may close up to three tokens, which the
// output register drains one token per cycle while m_tready is high. A
// four-entry queue of token groups sits between lexer and output, so s_tready
// drops only when that queue is full.
module dialog_script_lexer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] token_start, [31:16] token_stop
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last_of_run
);
    import dsl_pkg::*;

    logic     accept, push, pop;
    bundle_t  push_data, head;
    q_stat_t  q_stat;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    dsl_front #(.OB(OFFSET_BITS)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .in_byte    (s_tdata),
        .stream_end (s_tlast),
        .push       (push),
        .bundle     (push_data)
    );

    dsl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    dsl_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (q_stat.head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ src/dsl_front.sv @@
module dsl_front #(
    parameter int OB = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             stream_end,
    output logic             push,
    output dsl_pkg::bundle_t bundle
);
    import dsl_pkg::*;

    localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};

    lex_mode_t      mode_reg, mode_next;
    logic [OB-1:0]  pos_reg, pos_next;
    logic [OB-1:0]  start_reg, start_next;
    logic [3:0]     kw_cnt_reg, kw_cnt_next;
    logic           kw_ok_reg, kw_ok_next;
    logic [7:0]     prev_reg, prev_next;
    logic           brk_reg, brk_next;
    logic [1:0]     nph_reg, nph_next;

    logic [OB-1:0]  pos_inc, pos_dec;
    logic           nl0, identc, kw_full, kw_hit, run_idle;
    logic [1:0]     n;
    tok_t [MAX_TOK-1:0] toks;
    tok_kind_t      code_kind;

    function automatic tok_t mk(input tok_kind_t k, input logic [OB-1:0] s,
                                input logic [OB-1:0] e);
        tok_t t;
        t.kind  = k;
        t.start = TOK_OFF_W'(s);
        t.stop  = TOK_OFF_W'(e);
        return t;
    endfunction

    // Shared byte decode
    assign pos_inc   = (pos_reg == OFF_MAX) ? OFF_MAX : pos_reg + 1'b1;
    assign pos_dec   = (pos_reg == '0) ? '0 : pos_reg - 1'b1;
    assign nl0       = (in_byte == CH_NL) || (in_byte == CH_NUL);
    assign identc    = is_alpha(in_byte) || is_digit(in_byte) || (in_byte == CH_USCORE);
    assign kw_full   = kw_ok_reg && (kw_cnt_reg == KW_LEN);
    assign kw_hit    = kw_ok_reg && (kw_cnt_reg < KW_LEN) && (in_byte == kw_char(kw_cnt_reg));
    assign code_kind = (mode_reg == M_CODE) ? K_CODE : K_WAIT;

    // Does the byte fall through to the idle decoder after closing a token
    always_comb begin
        run_idle = 1'b0;
        unique case (mode_reg)
            M_IDLE:   run_idle = 1'b1;
            M_NUMBER: run_idle = !((nph_reg == 2'd0) && (in_byte == CH_GT)) &&
                                 !is_digit(in_byte) &&
                                 !((in_byte == CH_DOT) && (nph_reg < 2'd2));
            M_IDENT:  run_idle = !identc && (!kw_full || nl0);
            M_CODE, M_WAIT:
                      run_idle = !(brk_reg && (in_byte != CH_SP)) && nl0;
            M_DOLLAR: run_idle = (in_byte == CH_LBRK) || (in_byte == CH_SP) || nl0;
            M_COND, M_STRING, M_COMMENT:
                      run_idle = 1'b0;
            default:  run_idle = 1'b1;
        endcase
    end

    // Next state
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_inc;
        start_next  = start_reg;
        kw_cnt_next = kw_cnt_reg;
        kw_ok_next  = kw_ok_reg;
        prev_next   = prev_reg;
        brk_next    = brk_reg;
        nph_next    = nph_reg;
        if (stream_end) begin
            mode_next   = M_IDLE;
            pos_next    = '0;
            start_next  = '0;
            kw_cnt_next = 4'd0;
            kw_ok_next  = 1'b1;
            prev_next   = CH_NUL;
            brk_next    = 1'b0;
            nph_next    = 2'd0;
        end else begin
            unique case (mode_reg)
                M_NUMBER: begin
                    if ((nph_reg == 2'd0) && (in_byte == CH_GT)) begin
                        mode_next = M_IDLE;
                    end else if (is_digit(in_byte)) begin
                        if (nph_reg == 2'd0) nph_next = 2'd1;
                    end else if ((in_byte == CH_DOT) && (nph_reg < 2'd2)) begin
                        nph_next = 2'd2;
                    end
                end
                M_IDENT: begin
                    if (identc) begin
                        if (kw_hit) kw_cnt_next = kw_cnt_reg + 4'd1;
                        else kw_ok_next = 1'b0;
                    end else if (kw_full) begin
                        // keyword seen: carry on as code
                        mode_next = M_WAIT;
                        brk_next  = 1'b0;
                        prev_next = nl0 ? CH_NUL : in_byte;
                    end
                end
                M_CODE, M_WAIT: begin
                    brk_next = 1'b0;
                    if (brk_reg && (in_byte != CH_SP)) begin
                        // split before the bracket, bracket opens a condition
                        start_next = pos_dec;
                        mode_next  = (in_byte == CH_RBRK) ? M_IDLE : M_COND;
                    end else if (!nl0) begin
                        brk_next  = (prev_reg == CH_SP) && (in_byte == CH_LBRK);
                        prev_next = in_byte;
                    end
                end
                M_COND:    if (in_byte == CH_RBRK) mode_next = M_IDLE;
                M_STRING:  if (in_byte == CH_QUOTE) mode_next = M_IDLE;
                M_COMMENT: if (in_byte == CH_NL) mode_next = M_IDLE;
                default: ;
            endcase
            if (run_idle) begin
                mode_next = M_IDLE;
                unique case (in_byte) inside
                    CH_NUL: begin
                        pos_next    = '0;
                        start_next  = '0;
                        kw_cnt_next = 4'd0;
                        kw_ok_next  = 1'b1;
                        prev_next   = CH_NUL;
                        brk_next    = 1'b0;
                        nph_next    = 2'd0;
                    end
                    CH_BANG, CH_DOLLAR, CH_LBRK, CH_QUOTE: begin
                        mode_next  = (in_byte == CH_BANG)   ? M_CODE :
                                     (in_byte == CH_DOLLAR) ? M_DOLLAR :
                                     (in_byte == CH_LBRK)   ? M_COND : M_STRING;
                        start_next = pos_reg;
                        prev_next  = CH_NUL;
                        brk_next   = 1'b0;
                    end
                    CH_HASH, CH_SEMI: mode_next = M_COMMENT;
                    CH_MINUS: begin
                        mode_next  = M_NUMBER;
                        start_next = pos_reg;
                        nph_next   = 2'd0;
                    end
                    default: begin
                        if (is_digit(in_byte)) begin
                            mode_next  = M_NUMBER;
                            start_next = pos_reg;
                            nph_next   = 2'd1;
                        end else if (is_alpha(in_byte)) begin
                            mode_next   = M_IDENT;
                            start_next  = pos_reg;
                            kw_cnt_next = (in_byte == kw_char(4'd0)) ? 4'd1 : 4'd0;
                            kw_ok_next  = (in_byte == kw_char(4'd0));
                        end
                    end
                endcase
            end
        end
    end

    // Tokens caused by this item
    always_comb begin
        n    = 2'd0;
        toks = '0;
        if (stream_end) begin
            unique case (mode_reg)
                M_NUMBER: begin toks[n] = mk(K_NUMBER, start_reg, pos_reg); n = n + 2'd1; end
                M_IDENT: begin
                    toks[n] = mk(kw_full ? K_WAIT : K_IDENT, start_reg, pos_reg);
                    n = n + 2'd1;
                end
                M_CODE, M_WAIT: begin
                    if (brk_reg) begin
                        toks[n] = mk(code_kind, start_reg, pos_dec);
                        n = n + 2'd1;
                        toks[n] = mk(K_COND, pos_dec, pos_reg);
                        n = n + 2'd1;
                    end else begin
                        toks[n] = mk(code_kind, start_reg, pos_reg);
                        n = n + 2'd1;
                    end
                end
                M_DOLLAR: begin toks[n] = mk(K_DOLLAR, start_reg, pos_reg); n = n + 2'd1; end
                M_COND:   begin toks[n] = mk(K_COND, start_reg, pos_reg);   n = n + 2'd1; end
                M_STRING: begin toks[n] = mk(K_STRING, start_reg, pos_reg); n = n + 2'd1; end
                default: ;
            endcase
            toks[n] = mk(K_END, pos_reg, pos_reg);
            n = n + 2'd1;
        end else begin
            unique case (mode_reg)
                M_NUMBER: begin
                    if ((nph_reg == 2'd0) && (in_byte == CH_GT)) begin
                        toks[n] = mk(K_GOTO, start_reg, pos_inc);
                        n = n + 2'd1;
                    end else if (run_idle) begin
                        toks[n] = mk(K_NUMBER, start_reg, pos_reg);
                        n = n + 2'd1;
                    end
                end
                M_IDENT: begin
                    if (!identc && (!kw_full || nl0)) begin
                        toks[n] = mk(kw_full ? K_WAIT : K_IDENT, start_reg, pos_reg);
                        n = n + 2'd1;
                    end
                end
                M_CODE, M_WAIT: begin
                    if (brk_reg && (in_byte != CH_SP)) begin
                        toks[n] = mk(code_kind, start_reg, pos_dec);
                        n = n + 2'd1;
                        if (in_byte == CH_RBRK) begin
                            toks[n] = mk(K_COND, pos_dec, pos_inc);
                            n = n + 2'd1;
                        end
                    end else if (nl0) begin
                        toks[n] = mk(code_kind, start_reg, pos_reg);
                        n = n + 2'd1;
                    end
                end
                M_DOLLAR: begin
                    if (run_idle) begin
                        toks[n] = mk(K_DOLLAR, start_reg, pos_reg);
                        n = n + 2'd1;
                    end
                end
                M_COND: begin
                    if (in_byte == CH_RBRK) begin
                        toks[n] = mk(K_COND, start_reg, pos_inc);
                        n = n + 2'd1;
                    end
                end
                M_STRING: begin
                    if (in_byte == CH_QUOTE) begin
                        toks[n] = mk(K_STRING, start_reg, pos_inc);
                        n = n + 2'd1;
                    end
                end
                default: ;
            endcase
            if (run_idle) begin
                unique case (in_byte) inside
                    CH_NUL:   begin toks[n] = mk(K_END, pos_reg, pos_inc);    n = n + 2'd1; end
                    CH_COLON: begin toks[n] = mk(K_COLON, pos_reg, pos_inc);  n = n + 2'd1; end
                    CH_EQ:    begin toks[n] = mk(K_ASSIGN, pos_reg, pos_inc); n = n + 2'd1; end
                    default: ;
                endcase
            end
        end
    end

    assign push        = accept && (n != 2'd0);
    assign bundle.cnt  = n;
    assign bundle.toks = toks;

    // Lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            start_reg  <= '0;
            kw_cnt_reg <= 4'd0;
            kw_ok_reg  <= 1'b1;
            prev_reg   <= CH_NUL;
            brk_reg    <= 1'b0;
            nph_reg    <= 2'd0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            kw_cnt_reg <= kw_cnt_next;
            kw_ok_reg  <= kw_ok_next;
            prev_reg   <= prev_next;
            brk_reg    <= brk_next;
            nph_reg    <= nph_next;
        end
    end

endmodule

@@ src/dsl_queue.sv @@
module dsl_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  dsl_pkg::bundle_t push_data,
    input  logic             pop,
    output dsl_pkg::bundle_t head,
    output dsl_pkg::q_stat_t stat
);
    import dsl_pkg::*;

    bundle_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg, count_next;

    assign head            = mem_reg[rd_ptr_reg];
    assign stat.head_valid = (count_reg != '0);
    assign stat.full       = (count_reg == (QPTR_W + 1)'(QDEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (!push && pop) count_next = count_reg - 1'b1;
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/dsl_back.sv @@
module dsl_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  dsl_pkg::bundle_t head,
    input  logic             head_valid,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,
    output logic [3:0]       m_tuser,
    output logic             m_tlast
);
    import dsl_pkg::*;

    logic [1:0]  idx_reg;
    logic        valid_reg;
    tok_t        tok_reg;
    logic        last_reg;
    logic        load, last;

    // One token of the head bundle per cycle into the output register while it is empty or taken
    assign load = head_valid && (!valid_reg || m_tready);
    assign last = (idx_reg == (head.cnt - 2'd1));
    assign pop  = load && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= last ? 2'd0 : idx_reg + 2'd1;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= head.toks[idx_reg];
            last_reg <= last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {tok_reg.stop, tok_reg.start};
    assign m_tuser  = tok_reg.kind;
    assign m_tlast  = last_reg;

endmodule

@@ src/dsl_checker.sv @@
module dsl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    import dsl_pkg::*;

    // A stalled token holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled token changed");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("token valid after reset");

    // End always closes the run of its item
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == K_END) |-> m_tlast)
        else $error("end token not last of run");

    // Kind stays within the defined codes
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= 4'(K_WAIT)))
        else $error("undefined token kind");

endmodule

bind dialog_script_lexer dsl_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ dv/tb_dialog_script_lexer.sv @@
`timescale 1ns / 1ps

module tb_dialog_script_lexer;
    import dsl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [15:0] OFFSET_TOP = 16'hFFFF;
    localparam logic [71:0] KEYWORD = "waitwhile";

    // Shapes of script text the random part is built from
    typedef enum int {
        PC_ASSIGN, PC_COLON, PC_GOTO, PC_NUMBER, PC_IDENT, PC_KEYWORD, PC_CODE,
        PC_DOLLAR, PC_COND, PC_STRING, PC_COMMENT, PC_BLANK,
        PC_NOISE, PC_ZERO, PC_EOS, PC_CUT
    } piece_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] start;
        logic [15:0] stop;
        logic        last;
    } lexed_tok_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
    logic        s_tlast = 1'b0;    // stream_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [15:0] token_start, [31:16] token_stop
    logic [3:0]  m_tuser;           // [3:0] token_kind
    logic        m_tlast;           // last_of_run

    dialog_script_lexer #(.OFFSET_BITS(16)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Lexer state as the testbench tracks it
    lex_mode_t   lex_state;
    logic [15:0] next_offset;
    logic [15:0] tok_begin;
    logic [3:0]  kw_hits;
    logic        kw_alive;
    logic [7:0]  code_prev;
    logic        split_pending;
    logic [1:0]  num_part;

    lexed_tok_t step_toks[$];      // tokens of the item being lexed
    lexed_tok_t lexed_tokens[$];   // tokens still to come out of the block
    lexed_tok_t head_tok;

    int mismatches = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit calm_sender = 1'b0;
    int stall_window = 0;
    int stall_pct = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic bit digit_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit letter_byte(input logic [7:0] b);
        return (b | 8'h20) >= "a" && (b | 8'h20) <= "z";
    endfunction

    function automatic logic [15:0] offset_after(input logic [15:0] p);
        return (p == OFFSET_TOP) ? p : p + 16'd1;
    endfunction

    function automatic logic [15:0] offset_before(input logic [15:0] p);
        return (p != 16'd0) ? p - 16'd1 : 16'd0;
    endfunction

    function automatic void lex_clear();
        lex_state = M_IDLE;
        next_offset = '0;
        tok_begin = '0;
        kw_hits = '0;
        kw_alive = 1'b1;
        code_prev = CH_NUL;
        split_pending = 1'b0;
        num_part = '0;
    endfunction

    function automatic void kw_advance(input logic [7:0] b);
        if (kw_alive && kw_hits < KW_LEN && b == KEYWORD[71 - 8 * kw_hits -: 8])
            kw_hits++;
        else
            kw_alive = 1'b0;
    endfunction

    function automatic bit keyword_done();
        return kw_alive && kw_hits == KW_LEN;
    endfunction

    function automatic void put_tok(input tok_kind_t k, input logic [15:0] s,
                                    input logic [15:0] e);
        lexed_tok_t t;
        t.kind = k;
        t.start = s;
        t.stop = e;
        t.last = 1'b0;
        if (step_toks.size() < MAX_TOK)
            step_toks.insert(step_toks.size(), t);
    endfunction

    // Tokens caused by one accepted item, queued in output order
    function automatic void lex_step(input logic [7:0] b, input logic eos);
        logic [15:0] at;
        logic        again;
        tok_kind_t   code_kind;
        lexed_tok_t  t;
        step_toks.delete();
        at = next_offset;
        if (eos) begin
            // close whatever is open, then End at the current offset
            case (lex_state)
                M_NUMBER: put_tok(K_NUMBER, tok_begin, at);
                M_IDENT:  put_tok(keyword_done() ? K_WAIT : K_IDENT, tok_begin, at);
                M_CODE, M_WAIT: begin
                    if (lex_state == M_CODE) code_kind = K_CODE;
                    else code_kind = K_WAIT;
                    if (split_pending) begin
                        put_tok(code_kind, tok_begin, offset_before(at));
                        put_tok(K_COND, offset_before(at), at);
                    end else begin
                        put_tok(code_kind, tok_begin, at);
                    end
                end
                M_DOLLAR: put_tok(K_DOLLAR, tok_begin, at);
                M_COND:   put_tok(K_COND, tok_begin, at);
                M_STRING: put_tok(K_STRING, tok_begin, at);
                default: ;
            endcase
            put_tok(K_END, at, at);
            lex_clear();
        end else begin
            next_offset = offset_after(at);
            again = 1'b1;
            while (again) begin
                again = 1'b0;
                case (lex_state)
                    M_IDLE: begin
                        if (b == CH_NUL) begin
                            put_tok(K_END, at, offset_after(at));
                            lex_clear();
                        end else if (b == CH_BANG || b == CH_DOLLAR || b == CH_LBRK ||
                                     b == CH_QUOTE) begin
                            case (b)
                                CH_BANG:   lex_state = M_CODE;
                                CH_DOLLAR: lex_state = M_DOLLAR;
                                CH_LBRK:   lex_state = M_COND;
                                default:   lex_state = M_STRING;
                            endcase
                            tok_begin = at;
                            code_prev = CH_NUL;
                            split_pending = 1'b0;
                        end else if (b == CH_COLON) begin
                            put_tok(K_COLON, at, offset_after(at));
                        end else if (b == CH_EQ) begin
                            put_tok(K_ASSIGN, at, offset_after(at));
                        end else if (b == CH_HASH || b == CH_SEMI) begin
                            lex_state = M_COMMENT;
                        end else if (b == CH_MINUS) begin
                            lex_state = M_NUMBER;
                            tok_begin = at;
                            num_part = 2'd0;
                        end else if (digit_byte(b)) begin
                            lex_state = M_NUMBER;
                            tok_begin = at;
                            num_part = 2'd1;
                        end else if (letter_byte(b)) begin
                            lex_state = M_IDENT;
                            tok_begin = at;
                            kw_hits = '0;
                            kw_alive = 1'b1;
                            kw_advance(b);
                        end
                    end
                    M_NUMBER: begin
                        if (num_part == 2'd0 && b == CH_GT) begin
                            put_tok(K_GOTO, tok_begin, offset_after(at));
                            lex_state = M_IDLE;
                        end else if (digit_byte(b)) begin
                            if (num_part == 2'd0) num_part = 2'd1;
                        end else if (b == CH_DOT && num_part < 2'd2) begin
                            num_part = 2'd2;
                        end else begin
                            put_tok(K_NUMBER, tok_begin, at);
                            lex_state = M_IDLE;
                            again = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (letter_byte(b) || digit_byte(b) || b == CH_USCORE) begin
                            kw_advance(b);
                        end else if (keyword_done()) begin
                            // keyword turns into a code line
                            lex_state = M_WAIT;
                            code_prev = CH_NUL;
                            split_pending = 1'b0;
                            again = 1'b1;
                        end else begin
                            put_tok(K_IDENT, tok_begin, at);
                            lex_state = M_IDLE;
                            again = 1'b1;
                        end
                    end
                    M_CODE, M_WAIT: begin
                        if (lex_state == M_CODE) code_kind = K_CODE;
                        else code_kind = K_WAIT;
                        if (split_pending && b != CH_SP) begin
                            // " [x": code stops before the bracket, which opens a condition
                            split_pending = 1'b0;
                            put_tok(code_kind, tok_begin, offset_before(at));
                            tok_begin = offset_before(at);
                            lex_state = M_COND;
                            again = 1'b1;
                        end else begin
                            split_pending = 1'b0;
                            if (b == CH_NL || b == CH_NUL) begin
                                put_tok(code_kind, tok_begin, at);
                                lex_state = M_IDLE;
                                again = 1'b1;
                            end else begin
                                if (code_prev == CH_SP && b == CH_LBRK) split_pending = 1'b1;
                                code_prev = b;
                            end
                        end
                    end
                    M_DOLLAR: begin
                        if (b == CH_LBRK || b == CH_SP || b == CH_NL || b == CH_NUL) begin
                            put_tok(K_DOLLAR, tok_begin, at);
                            lex_state = M_IDLE;
                            again = 1'b1;
                        end
                    end
                    M_COND: begin
                        if (b == CH_RBRK) begin
                            put_tok(K_COND, tok_begin, offset_after(at));
                            lex_state = M_IDLE;
                        end
                    end
                    M_STRING: begin
                        if (b == CH_QUOTE) begin
                            put_tok(K_STRING, tok_begin, offset_after(at));
                            lex_state = M_IDLE;
                        end
                    end
                    M_COMMENT: begin
                        if (b == CH_NL) lex_state = M_IDLE;
                    end
                    default: begin
                        lex_state = M_IDLE;
                        again = 1'b1;
                    end
                endcase
            end
        end
        foreach (step_toks[i]) begin
            t = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            lexed_tokens.insert(lexed_tokens.size(), t);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts with random gaps, one item per call
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input logic eos);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!calm_sender) begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                s_tdata <= 8'($urandom_range(0, 255));
                s_tlast <= 1'($urandom_range(0, 1));
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eos;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lex_step(b, eos);
        burst_left--;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Random script text
    // ------------------------------------------------------------------
    function automatic logic [7:0] letter_pick();
        logic [7:0] c;
        c = 8'("a" + $urandom_range(0, 25));
        if ($urandom_range(0, 1)) c = c & 8'hDF;
        return c;
    endfunction

    // body byte of a code line; never ends the line
    function automatic logic [7:0] code_byte();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = CH_SP;
            1: c = CH_LBRK;
            2: c = CH_RBRK;
            3: c = letter_pick();
            4: c = 8'("0" + $urandom_range(0, 9));
            default: begin
                c = 8'($urandom_range(1, 255));
                if (c == CH_NL) c = CH_SP;
            end
        endcase
        return c;
    endfunction

    // content of a condition, string or comment; zero kept out when filling
    function automatic logic [7:0] content_byte(input logic [7:0] closer, input bit fill);
        logic [7:0] c;
        c = 8'($urandom_range(fill ? 1 : 0, 255));
        if (c == closer) c = "a";
        return c;
    endfunction

    // append one byte (with its stream end flag on top) to a piece
    function automatic void queue_byte(ref logic [8:0] q[$], input logic [8:0] v);
        q.insert(q.size(), v);
    endfunction

    task automatic send_script_piece(input bit fill, output int counted);
        logic [8:0]  piece[$];
        piece_kind_t pick;
        int          n;
        int          v;
        logic [7:0]  c;
        pick = piece_kind_t'($urandom_range(0, fill ? int'(PC_BLANK) : int'(PC_CUT)));
        case (pick)
            PC_ASSIGN: queue_byte(piece, {1'b0, CH_EQ});
            PC_COLON:  queue_byte(piece, {1'b0, CH_COLON});
            PC_GOTO: begin
                queue_byte(piece, {1'b0, CH_MINUS});
                queue_byte(piece, {1'b0, CH_GT});
            end
            PC_NUMBER: begin
                if ($urandom_range(0, 1)) queue_byte(piece, {1'b0, CH_MINUS});
                n = $urandom_range(0, 3);
                repeat (n) queue_byte(piece, {1'b0, 8'("0" + $urandom_range(0, 9))});
                if ($urandom_range(0, 1)) begin
                    queue_byte(piece, {1'b0, CH_DOT});
                    n = $urandom_range(0, 3);
                    repeat (n) queue_byte(piece, {1'b0, 8'("0" + $urandom_range(0, 9))});
                end
            end
            PC_IDENT: begin
                queue_byte(piece, {1'b0, letter_pick()});
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 2))
                        0: c = letter_pick();
                        1: c = 8'("0" + $urandom_range(0, 9));
                        default: c = CH_USCORE;
                    endcase
                    queue_byte(piece, {1'b0, c});
                end
            end
            PC_KEYWORD, PC_CODE: begin
                v = $urandom_range(0, 2);
                if (pick == PC_CODE) begin
                    queue_byte(piece, {1'b0, CH_BANG});
                    v = 0;
                end else if (v == 2) begin
                    n = $urandom_range(1, 8);
                    for (int i = 0; i < n; i++) queue_byte(piece, {1'b0, KEYWORD[71 - 8 * i -: 8]});
                end else begin
                    for (int i = 0; i < 9; i++) queue_byte(piece, {1'b0, KEYWORD[71 - 8 * i -: 8]});
                    if (v == 1) queue_byte(piece, {1'b0, 8'("s")});
                end
                if (v == 0) begin
                    n = $urandom_range(0, 8);
                    repeat (n) queue_byte(piece, {1'b0, code_byte()});
                    case (fill ? 0 : $urandom_range(0, 4))
                        3: queue_byte(piece, {1'b0, CH_NUL});
                        4: queue_byte(piece, {1'b1, 8'($urandom_range(0, 255))});
                        default: queue_byte(piece, {1'b0, CH_NL});
                    endcase
                end
            end
            PC_DOLLAR: begin
                queue_byte(piece, {1'b0, CH_DOLLAR});
                n = $urandom_range(1, 4);
                repeat (n) queue_byte(piece, {1'b0, letter_pick()});
                case ($urandom_range(0, fill ? 2 : 3))
                    0: queue_byte(piece, {1'b0, CH_SP});
                    1: queue_byte(piece, {1'b0, CH_NL});
                    2: begin
                        queue_byte(piece, {1'b0, CH_LBRK});
                        queue_byte(piece, {1'b0, letter_pick()});
                        queue_byte(piece, {1'b0, CH_RBRK});
                    end
                    default: queue_byte(piece, {1'b0, CH_NUL});
                endcase
            end
            PC_COND, PC_STRING, PC_COMMENT: begin
                case (pick)
                    PC_COND: begin
                        queue_byte(piece, {1'b0, CH_LBRK});
                        c = CH_RBRK;
                    end
                    PC_STRING: begin
                        queue_byte(piece, {1'b0, CH_QUOTE});
                        c = CH_QUOTE;
                    end
                    default: begin
                        queue_byte(piece, {1'b0, $urandom_range(0, 1) ? CH_HASH : CH_SEMI});
                        c = CH_NL;
                    end
                endcase
                n = $urandom_range(0, 6);
                repeat (n) queue_byte(piece, {1'b0, content_byte(c, fill)});
                queue_byte(piece, {1'b0, c});
            end
            PC_BLANK: begin
                n = $urandom_range(1, 3);
                repeat (n) queue_byte(piece, {1'b0, $urandom_range(0, 1) ? CH_SP : CH_NL});
            end
            PC_NOISE: queue_byte(piece, {1'b0, 8'($urandom_range(0, 255))});
            PC_ZERO:  queue_byte(piece, {1'b0, CH_NUL});
            PC_EOS:   queue_byte(piece, {1'b1, 8'($urandom_range(0, 255))});
            default: begin
                // token cut short by the end of the stream
                case ($urandom_range(0, 5))
                    0: c = CH_BANG;
                    1: c = CH_DOLLAR;
                    2: c = CH_LBRK;
                    3: c = CH_QUOTE;
                    4: c = CH_MINUS;
                    default: c = letter_pick();
                endcase
                queue_byte(piece, {1'b0, c});
                n = $urandom_range(0, 3);
                repeat (n) queue_byte(piece, {1'b0, code_byte()});
                queue_byte(piece, {1'b1, 8'($urandom_range(0, 255))});
            end
        endcase
        if (fill || $urandom_range(0, 2) != 0)
            queue_byte(piece, {1'b0, $urandom_range(0, 3) == 0 ? CH_NL : CH_SP});
        counted = (pick == PC_BLANK) ? 0 : piece.size();
        foreach (piece[i]) send_item(piece[i][7:0], piece[i][8]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // assign, colon, goto, number, ident cut by a high byte, End from a zero byte
    task automatic test_single_byte_tokens();
        send_text("=:->-1.5x");
        send_item(8'hFF, 1'b0);
        send_item(CH_NUL, 1'b0);
    endtask

    // split of code at " [", dollar, string holding a zero byte
    task automatic test_code_bracket_split();
        send_text("!a [b]\n$v \"");
        send_item(CH_NUL, 1'b0);
        send_text("\"");
    endtask

    // stream end with a bracket pending gives three tokens
    task automatic test_stream_end_open();
        send_text("! [");
        send_item(8'h5A, 1'b1);
    endtask

    task automatic test_random_script();
        int total;
        int n;
        total = 0;
        while (total < 270) begin
            if ($urandom_range(0, 19) == 0) calm_sender = ~calm_sender;
            send_script_piece(1'b0, n);
            total += n;
        end
        calm_sender = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver stalls: random duty that changes from window to window
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_window == 0) begin
            stall_window <= $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0: stall_pct <= 0;
                1: stall_pct <= 25;
                2: stall_pct <= 60;
                default: stall_pct <= 90;
            endcase
        end else begin
            stall_window <= stall_window - 1;
        end
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each token leaving the block with the oldest one predicted
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (lexed_tokens.size() == 0) begin
                $display("%0t: expected no token, got kind %0d start %0d stop %0d last %0b",
                         $time, m_tuser, m_tdata[15:0], m_tdata[31:16], m_tlast);
                mismatches++;
            end else begin
                head_tok = lexed_tokens.pop_front();
                if (m_tuser !== head_tok.kind) begin
                    $display("%0t: kind expected %0d got %0d", $time, head_tok.kind, m_tuser);
                    mismatches++;
                end
                if (m_tdata[15:0] !== head_tok.start) begin
                    $display("%0t: start expected %0d got %0d",
                             $time, head_tok.start, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[31:16] !== head_tok.stop) begin
                    $display("%0t: stop expected %0d got %0d",
                             $time, head_tok.stop, m_tdata[31:16]);
                    mismatches++;
                end
                if (m_tlast !== head_tok.last) begin
                    $display("%0t: last expected %0b got %0b", $time, head_tok.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_dialog_script_lexer NOT OK");
            $finish;
        end
    end

    initial begin
        lex_clear();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        test_single_byte_tokens();
        test_code_bracket_split();
        test_stream_end_open();
        test_random_script();

        s_tvalid <= 1'b0;
        while (lexed_tokens.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_dialog_script_lexer OK");
        else
            $display("tb_dialog_script_lexer NOT OK");
        $finish;
    end

endmodule
